// ----- rtl/cqfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqfb_pkg
// shared constants, types and codes for the coverage quad fill blend core
// ----------------------------------------------------------------------------
package cqfb_pkg;

    localparam int SUBPIXEL_BITS   = 4;
    localparam int CHANNEL_BITS    = 12;
    localparam int TILE_WIDTH_DEF  = 64;
    localparam int TILE_HEIGHT_DEF = 64;

    localparam int UNORM_BITS = 8;
    localparam int UNORM_MAX  = (1 << UNORM_BITS) - 1;
    localparam int CH_W       = CHANNEL_BITS;
    localparam logic [CH_W-1:0] CH_ONE = CH_W'((1 << CH_W) - 1);
    localparam int SUB_ONE    = 1 << SUBPIXEL_BITS;
    localparam int OVL_W      = SUBPIXEL_BITS + 1;
    localparam int COV_W      = 2 * SUBPIXEL_BITS + 1;
    localparam int ACC_W      = UNORM_BITS + 2 * SUBPIXEL_BITS + CHANNEL_BITS;
    localparam int Q_W        = CH_W + 1;
    localparam int SCALE_HALF = (UNORM_MAX << (2 * SUBPIXEL_BITS)) / 2;

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_FILL  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    // spare code, ignored
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // register indexes
    localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

    // channel order in a pixel word
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef logic [3:0][CH_W-1:0] t_pixel;

    localparam t_pixel CLEAR_PIXEL = {CH_ONE, {(3 * CH_W){1'b0}}};

    typedef enum logic [3:0] {
        ALU_IDLE,
        ALU_SRC_MUL,
        ALU_SRC_SCALE,
        ALU_BLEND_MUL,
        ALU_READ_MUL,
        ALU_QUOT_255,
        ALU_QUOT_ONE,
        ALU_CORR_255,
        ALU_CORR_ONE
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [7:0]       colour;
        logic [COV_W-1:0] cov;
        logic [CH_W-1:0]  pix;
        logic [CH_W-1:0]  alpha;
    } t_alu_req;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_PIX_RD,
        ST_PIX_LOAD,
        ST_SRC_MUL,
        ST_SRC_SCALE,
        ST_SRC_QUOT,
        ST_SRC_CORR,
        ST_BLD_MUL,
        ST_BLD_QUOT,
        ST_BLD_CORR,
        ST_BLD_SUM,
        ST_PIX_WR,
        ST_RD_WAIT,
        ST_RD_MUL,
        ST_RD_QUOT,
        ST_RD_CORR,
        ST_RD_STORE,
        ST_RD_DONE
    } t_state;

endpackage

// ----- rtl/cqfb_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqfb_alu
// shared multiply and divide-by-constant unit, one step per cycle
// ----------------------------------------------------------------------------
module cqfb_alu
    import cqfb_pkg::*;
(
    input  logic           i_clk,
    input  t_alu_req       i_req,
    output logic [Q_W-1:0] o_quot
);

    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [Q_W-1:0]          r_quot, n_quot;
    logic [ACC_W+UNORM_BITS:0] w_mul255;
    logic [ACC_W+CH_W:0]     w_mulone;
    logic [ACC_W-1:0]        w_q;
    logic [ACC_W-1:0]        w_rem255;
    logic [ACC_W-1:0]        w_remone;

    always_comb begin
        // reciprocal estimates, low by at most one
        w_mul255 = {{(UNORM_BITS + 1){1'b0}}, r_acc}
                 + ({{(UNORM_BITS + 1){1'b0}}, r_acc} << UNORM_BITS);
        w_mulone = {{(CH_W + 1){1'b0}}, r_acc} + ({{(CH_W + 1){1'b0}}, r_acc} << CH_W);
        w_q      = ACC_W'(r_quot);
        w_rem255 = r_acc - ((w_q << UNORM_BITS) - w_q);
        w_remone = r_acc - ((w_q << CH_W) - w_q);
        n_acc    = r_acc;
        n_quot   = r_quot;
        case (i_req.op)
            ALU_SRC_MUL: begin
                n_acc = ACC_W'(i_req.colour) * ACC_W'(i_req.cov);
            end
            ALU_SRC_SCALE: begin
                n_acc = ((r_acc << CH_W) - r_acc + ACC_W'(SCALE_HALF)) >> (2 * SUBPIXEL_BITS);
            end
            ALU_BLEND_MUL: begin
                n_acc = ACC_W'(i_req.pix) * ACC_W'(CH_ONE - i_req.alpha)
                      + ACC_W'(CH_ONE >> 1);
            end
            ALU_READ_MUL: begin
                n_acc = ACC_W'(i_req.pix) * ACC_W'(UNORM_MAX) + ACC_W'(CH_ONE >> 1);
            end
            ALU_QUOT_255: begin
                n_quot = Q_W'(w_mul255 >> (2 * UNORM_BITS));
            end
            ALU_QUOT_ONE: begin
                n_quot = Q_W'(w_mulone >> (2 * CH_W));
            end
            ALU_CORR_255: begin
                if (w_rem255 >= ACC_W'(UNORM_MAX)) begin
                    n_quot = r_quot + Q_W'(1);
                end
            end
            ALU_CORR_ONE: begin
                if (w_remone >= ACC_W'(CH_ONE)) begin
                    n_quot = r_quot + Q_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

// ----- rtl/coverage_quad_fill_blend_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_quad_fill_blend_core
// antialiased quad fill with premultiplied source-over into a tile store
// ----------------------------------------------------------------------------
// clear: one pixel word written per cycle across the whole tile
// fill: source scaling and blend on the single shared alu, 4 channels per
//   covered pixel; skipped columns and rows are stepped over one by one
// read: multiply, quotient and correction per channel, result held in an
//   output register, request is taken again once the read is handed over
// reset (synchronous, active low) starts a clearing pass over the whole tile;
//   no request is taken until it ends
// ----------------------------------------------------------------------------
module coverage_quad_fill_blend_core
    import cqfb_pkg::*;
#(
    parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic signed [15:0] i_quad_left,
    input  logic signed [15:0] i_quad_top,
    input  logic [15:0] i_quad_span_x,
    input  logic [15:0] i_quad_span_y,
    input  logic [7:0]  i_fill_red,
    input  logic [7:0]  i_fill_green,
    input  logic [7:0]  i_fill_blue,
    input  logic [7:0]  i_fill_alpha,
    input  logic [5:0]  i_read_col,
    input  logic [5:0]  i_read_row,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    localparam int DEPTH = TILE_WIDTH * TILE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XC_W  = $clog2(TILE_WIDTH + 1);
    localparam int YC_W  = $clog2(TILE_HEIGHT + 1);
    localparam int PC_W  = ((XC_W > YC_W) ? XC_W : YC_W) + SUBPIXEL_BITS + 1;
    // wide enough for the quad far edge (16-bit origin plus 16-bit span)
    localparam int CO_W  = (PC_W > 19) ? PC_W : 19;

    // pixel cell [p, p+1) against span [lo, hi), in subpixel units
    function automatic logic [OVL_W-1:0] cell_overlap(
        input logic signed [CO_W-1:0] p,
        input logic signed [CO_W-1:0] lo,
        input logic signed [CO_W-1:0] hi
    );
        logic signed [CO_W-1:0] a;
        logic signed [CO_W-1:0] b;
        a = p <<< SUBPIXEL_BITS;
        b = a + signed'(CO_W'(SUB_ONE));
        if (lo > a) begin
            a = lo;
        end
        if (hi < b) begin
            b = hi;
        end
        if (b > a) begin
            return OVL_W'(b - a);
        end
        return '0;
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [XC_W-1:0]    r_x, n_x;
    logic [YC_W-1:0]    r_y, n_y;
    logic [1:0]         r_ch, n_ch;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_out_valid, n_out_valid;
    logic [6:0]         r_active_width, r_active_height;

    // payload
    logic signed [CO_W-1:0] r_left, r_right, r_top, r_bottom;
    logic [3:0][7:0]    r_colour;
    logic [OVL_W-1:0]   r_ox, n_ox, r_oy, n_oy;
    logic [COV_W-1:0]   r_cov, n_cov;
    t_pixel             r_pix, n_pix;
    logic [CH_W-1:0]    r_src, n_src, r_sa, n_sa;
    logic [3:0][7:0]    r_res, n_res;
    logic [3:0][7:0]    r_out, n_out;

    // frame store
    t_pixel             r_mem [DEPTH];
    t_pixel             r_rdata;
    logic               w_mem_we;
    t_pixel             w_mem_data;

    // helpers
    logic               w_accept;
    logic [XC_W-1:0]    w_clip_w;
    logic [YC_W-1:0]    w_clip_h;
    logic [OVL_W-1:0]   w_ox, w_oy;
    logic [CH_W:0]      w_sum;
    logic               w_read_out;
    t_alu_req           w_alu_req;
    logic [Q_W-1:0]     w_quot;

    cqfb_alu u_alu (
        .i_clk  (i_clk),
        .i_req  (w_alu_req),
        .o_quot (w_quot)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // active size saturates to the tile
    assign w_clip_w = (32'(r_active_width) > 32'(TILE_WIDTH)) ? XC_W'(TILE_WIDTH)
                                                              : XC_W'(r_active_width);
    assign w_clip_h = (32'(r_active_height) > 32'(TILE_HEIGHT)) ? YC_W'(TILE_HEIGHT)
                                                                : YC_W'(r_active_height);

    assign w_ox = cell_overlap(signed'(CO_W'(r_x)), r_left, r_right);
    assign w_oy = cell_overlap(signed'(CO_W'(r_y)), r_top, r_bottom);
    assign w_sum = {1'b0, r_src} + {1'b0, w_quot[CH_W-1:0]};
    assign w_read_out = (32'(i_read_col) >= 32'(TILE_WIDTH))
                     || (32'(i_read_row) >= 32'(TILE_HEIGHT));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_ch        = r_ch;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_cov       = r_cov;
        n_pix       = r_pix;
        n_src       = r_src;
        n_sa        = r_sa;
        n_res       = r_res;
        n_out       = r_out;
        w_mem_we    = 1'b0;
        w_mem_data  = r_pix;
        w_alu_req   = '{op: ALU_IDLE, colour: r_colour[r_ch], cov: r_cov,
                        pix: r_pix[r_ch], alpha: r_sa};
        case (r_state)
            ST_CLEAR: begin
                // whole tile, active size does not matter
                w_mem_we   = 1'b1;
                w_mem_data = CLEAR_PIXEL;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        ACT_FILL: begin
                            n_y     = '0;
                            n_state = ST_ROW;
                        end
                        ACT_READ: begin
                            n_ch = CH_RED;
                            if (w_read_out) begin
                                // outside a small tile reads as zero
                                n_res   = '0;
                                n_state = ST_RD_DONE;
                            end else begin
                                n_addr  = AW'(32'(i_read_row) * TILE_WIDTH
                                              + 32'(i_read_col));
                                n_state = ST_RD_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROW: begin
                if (r_y == w_clip_h) begin
                    n_state = ST_IDLE;
                end else if (w_oy == '0) begin
                    n_y = r_y + YC_W'(1);
                end else begin
                    n_oy    = w_oy;
                    n_x     = '0;
                    n_state = ST_COL;
                end
            end
            ST_COL: begin
                if (r_x == w_clip_w) begin
                    n_y     = r_y + YC_W'(1);
                    n_state = ST_ROW;
                end else if (w_ox == '0) begin
                    n_x = r_x + XC_W'(1);
                end else begin
                    n_ox    = w_ox;
                    n_addr  = AW'(32'(r_y) * TILE_WIDTH + 32'(r_x));
                    n_state = ST_PIX_RD;
                end
            end
            ST_PIX_RD: begin
                // area coverage, memory read in flight
                n_cov   = COV_W'(r_ox) * COV_W'(r_oy);
                n_ch    = CH_ALPHA;
                n_state = ST_PIX_LOAD;
            end
            ST_PIX_LOAD: begin
                n_pix   = r_rdata;
                n_state = ST_SRC_MUL;
            end
            ST_SRC_MUL: begin
                w_alu_req.op = ALU_SRC_MUL;
                n_state      = ST_SRC_SCALE;
            end
            ST_SRC_SCALE: begin
                w_alu_req.op = ALU_SRC_SCALE;
                n_state      = ST_SRC_QUOT;
            end
            ST_SRC_QUOT: begin
                w_alu_req.op = ALU_QUOT_255;
                n_state      = ST_SRC_CORR;
            end
            ST_SRC_CORR: begin
                w_alu_req.op = ALU_CORR_255;
                n_state      = ST_BLD_MUL;
            end
            ST_BLD_MUL: begin
                // alpha goes first so its source value weights every channel
                n_src        = w_quot[CH_W-1:0];
                w_alu_req.op = ALU_BLEND_MUL;
                if (r_ch == CH_ALPHA) begin
                    n_sa            = w_quot[CH_W-1:0];
                    w_alu_req.alpha = w_quot[CH_W-1:0];
                end
                n_state = ST_BLD_QUOT;
            end
            ST_BLD_QUOT: begin
                w_alu_req.op = ALU_QUOT_ONE;
                n_state      = ST_BLD_CORR;
            end
            ST_BLD_CORR: begin
                w_alu_req.op = ALU_CORR_ONE;
                n_state      = ST_BLD_SUM;
            end
            ST_BLD_SUM: begin
                // saturate at one
                n_pix[r_ch] = (w_sum > {1'b0, CH_ONE}) ? CH_ONE : w_sum[CH_W-1:0];
                if (r_ch == CH_BLUE) begin
                    n_state = ST_PIX_WR;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_SRC_MUL;
                end
            end
            ST_PIX_WR: begin
                w_mem_we = 1'b1;
                n_x      = r_x + XC_W'(1);
                n_state  = ST_COL;
            end
            ST_RD_WAIT: begin
                n_state = ST_RD_MUL;
            end
            ST_RD_MUL: begin
                w_alu_req.op  = ALU_READ_MUL;
                w_alu_req.pix = r_rdata[r_ch];
                n_state       = ST_RD_QUOT;
            end
            ST_RD_QUOT: begin
                w_alu_req.op = ALU_QUOT_ONE;
                n_state      = ST_RD_CORR;
            end
            ST_RD_CORR: begin
                w_alu_req.op = ALU_CORR_ONE;
                n_state      = ST_RD_STORE;
            end
            ST_RD_STORE: begin
                n_res[r_ch] = w_quot[7:0];
                if (r_ch == CH_ALPHA) begin
                    n_state = ST_RD_DONE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_RD_MUL;
                end
            end
            ST_RD_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_addr          <= '0;
            r_x             <= '0;
            r_y             <= '0;
            r_ch            <= '0;
            r_out_valid     <= 1'b0;
            r_active_width  <= 7'd64;
            r_active_height <= 7'd64;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_x         <= n_x;
            r_y         <= n_y;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data;
                    CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // request payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left   <= CO_W'(i_quad_left);
            r_right  <= CO_W'(i_quad_left) + signed'(CO_W'(i_quad_span_x));
            r_top    <= CO_W'(i_quad_top);
            r_bottom <= CO_W'(i_quad_top) + signed'(CO_W'(i_quad_span_y));
            r_colour <= {i_fill_alpha, i_fill_blue, i_fill_green, i_fill_red};
        end
        r_ox  <= n_ox;
        r_oy  <= n_oy;
        r_cov <= n_cov;
        r_pix <= n_pix;
        r_src <= n_src;
        r_sa  <= n_sa;
        r_res <= n_res;
        r_out <= n_out;
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_addr] <= w_mem_data;
        end
        r_rdata <= r_mem[r_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_out_alpha = r_out[3];

    // reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == ST_CLEAR)
        else $error("reset did not start the clearing pass");

    // fills never write outside the clipped area
    a_write_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PIX_WR |-> (r_x < w_clip_w) && (r_y < w_clip_h))
        else $error("pixel write outside the active area");

    // scaled source never exceeds one
    a_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BLD_MUL |-> w_quot <= Q_W'(CH_ONE))
        else $error("source channel above one");

    // a result appears only at the end of a read
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_RD_DONE)
        else $error("result without a read");

endmodule

// ----- sim/coverage_quad_fill_blend_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_quad_fill_blend_core_test
// drives clear, fill and read requests into the quad fill core, mirrors the
// tile in a fixed-point shadow and checks every pixel read back
// ----------------------------------------------------------------------------
module coverage_quad_fill_blend_core_test
    import cqfb_pkg::*;
();

    localparam int TW = 64;
    localparam int TH = 64;
    localparam longint CYCLE_LIMIT = 64'd100_000_000;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        span_x;
        logic [15:0]        span_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [5:0]         col;
        logic [5:0]         row;
    } t_request;

    localparam int REQ_W = $bits(t_request);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_colour8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = '0;
    logic signed [15:0] i_quad_left = '0;
    logic signed [15:0] i_quad_top = '0;
    logic [15:0] i_quad_span_x = '0;
    logic [15:0] i_quad_span_y = '0;
    logic [7:0]  i_fill_red = '0;
    logic [7:0]  i_fill_green = '0;
    logic [7:0]  i_fill_blue = '0;
    logic [7:0]  i_fill_alpha = '0;
    logic [5:0]  i_read_col = '0;
    logic [5:0]  i_read_row = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;

    coverage_quad_fill_blend_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the tile and the active-area registers
    logic [CH_W-1:0] shadow_tile [TW*TH][4];
    int unsigned     shadow_width;
    int unsigned     shadow_height;

    t_request  pending_requests [$];
    t_colour8  expected_pixels [$];
    int        mismatches = 0;
    longint    cycle_count = 0;
    int        sender_hold = 0;
    int        receiver_hold = 0;
    bit        long_hold_req = 1'b0;
    bit        driver_busy = 1'b0;

    function automatic int overlap_sub(int p, int lo, int hi);
        int a;
        int b;
        a = p * SUB_ONE;
        b = a + SUB_ONE;
        if (lo > a) a = lo;
        if (hi < b) b = hi;
        return (b > a) ? b - a : 0;
    endfunction

    function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    task automatic shadow_clear();
        for (int i = 0; i < TW*TH; i++) begin
            shadow_tile[i][0] = '0;
            shadow_tile[i][1] = '0;
            shadow_tile[i][2] = '0;
            shadow_tile[i][3] = CH_ONE;
        end
    endtask

    // coverage-scaled source over into the shadow, clipped to the active area
    task automatic shadow_fill(t_request r);
        int left, top, right, bottom, w, h, ox, oy;
        longint unsigned cov, keep, sum;
        longint unsigned src [4];
        logic [7:0] c [4];
        left   = r.left;
        top    = r.top;
        right  = left + int'(r.span_x);
        bottom = top + int'(r.span_y);
        w = (shadow_width > TW) ? TW : shadow_width;
        h = (shadow_height > TH) ? TH : shadow_height;
        c[0] = r.red; c[1] = r.green; c[2] = r.blue; c[3] = r.alpha;
        for (int y = 0; y < h; y++) begin
            oy = overlap_sub(y, top, bottom);
            if (oy == 0) continue;
            for (int x = 0; x < w; x++) begin
                ox = overlap_sub(x, left, right);
                if (ox == 0) continue;
                cov = longint'(ox) * longint'(oy);
                for (int k = 0; k < 4; k++)
                    src[k] = round_div(longint'(c[k]) * CH_ONE * cov,
                                       longint'(255) << (2 * SUBPIXEL_BITS));
                for (int k = 0; k < 4; k++) begin
                    keep = round_div(longint'(shadow_tile[y*TW+x][k]) * (CH_ONE - src[3]),
                                     CH_ONE);
                    sum = src[k] + keep;
                    if (sum > CH_ONE) sum = CH_ONE;
                    shadow_tile[y*TW+x][k] = sum[CH_W-1:0];
                end
            end
        end
    endtask

    function automatic logic [7:0] to_byte(logic [CH_W-1:0] v);
        return 8'(round_div(longint'(v) * 255, CH_ONE));
    endfunction

    // predict one accepted request
    task automatic predict_request(t_request r);
        t_colour8 p;
        int idx;
        case (r.action)
            ACT_CLEAR: shadow_clear();
            ACT_FILL:  shadow_fill(r);
            ACT_READ: begin
                idx = int'(r.row) * TW + int'(r.col);
                p.red   = to_byte(shadow_tile[idx][0]);
                p.green = to_byte(shadow_tile[idx][1]);
                p.blue  = to_byte(shadow_tile[idx][2]);
                p.alpha = to_byte(shadow_tile[idx][3]);
                expected_pixels.push_back(p);
            end
            default: ;
        endcase
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    function automatic t_request make_read(int col, int row);
        t_request r;
        r = '0;
        r.action = ACT_READ;
        r.col = 6'(col);
        r.row = 6'(row);
        return r;
    endfunction

    function automatic t_request make_fill(int l, int t, int sx, int sy,
                                           int cr, int cg, int cb, int ca);
        t_request r;
        r = '0;
        r.action = ACT_FILL;
        r.left = 16'(l); r.top = 16'(t); r.span_x = 16'(sx); r.span_y = 16'(sy);
        r.red = 8'(cr); r.green = 8'(cg); r.blue = 8'(cb); r.alpha = 8'(ca);
        return r;
    endfunction

    // random request, mostly reads and small quads near the tile, with random content in unused fields
    function automatic t_request random_request();
        t_request r;
        int pick;
        r = t_request'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r.action = ACT_CLEAR;
        end else if (pick < 5) begin
            r.action = ACT_SPARE;
        end else if (pick < 55) begin
            r.action = ACT_READ;
        end else begin
            r.action = ACT_FILL;
            if ($urandom_range(0, 9) != 0) begin
                r.left   = 16'(int'($urandom_range(0, 1100)) - 100);
                r.top    = 16'(int'($urandom_range(0, 1100)) - 100);
                r.span_x = 16'($urandom_range(0, 40));
                r.span_y = 16'($urandom_range(0, 40));
            end else if ($urandom_range(0, 1) == 0) begin
                // huge quads covering the active area, rare because they are slow
                r.left = -16'sd32768; r.top = -16'sd32768;
                r.span_x = 16'hffff; r.span_y = 16'hffff;
            end
            // otherwise origin and span keep their random bits and can reach far past the tile
        end
        return r;
    endfunction

    // driver: fed from the pending queue, random gaps between requests
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_in_valid && o_in_ready) begin
            predict_request({i_action, i_quad_left, i_quad_top, i_quad_span_x,
                             i_quad_span_y, i_fill_red, i_fill_green, i_fill_blue,
                             i_fill_alpha, i_read_col, i_read_row});
        end
        if (i_rst_n && driver_busy) begin
            if (!i_in_valid || o_in_ready) begin
                if (sender_hold > 0 || pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (sender_hold > 0) sender_hold <= sender_hold - 1;
                end else begin
                    t_request r;
                    r = pending_requests.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= r.action;
                    i_quad_left   <= r.left;
                    i_quad_top    <= r.top;
                    i_quad_span_x <= r.span_x;
                    i_quad_span_y <= r.span_y;
                    i_fill_red    <= r.red;
                    i_fill_green  <= r.green;
                    i_fill_blue   <= r.blue;
                    i_fill_alpha  <= r.alpha;
                    i_read_col    <= r.col;
                    i_read_row    <= r.row;
                    sender_hold   <= random_gap();
                end
            end
        end
    end

    // monitor: random receiver stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected pixel %h %h %h %h",
                                 o_out_red, o_out_green, o_out_blue, o_out_alpha);
                end else begin
                    t_colour8 e;
                    e = expected_pixels.pop_front();
                    if (e != {o_out_red, o_out_green, o_out_blue, o_out_alpha}) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("pixel mismatch exp r%h g%h b%h a%h got r%h g%h b%h a%h",
                                     e.red, e.green, e.blue, e.alpha,
                                     o_out_red, o_out_green, o_out_blue, o_out_alpha);
                    end
                end
            end
            if (long_hold_req && receiver_hold == 0) begin
                receiver_hold <= 400;
                long_hold_req <= 1'b0;
                i_out_ready   <= 1'b0;
            end else if (receiver_hold > 0) begin
                receiver_hold <= receiver_hold - 1;
                i_out_ready   <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 40) == 0) receiver_hold <= random_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        // a fill or clear may still be running after the last read
        repeat (TW * TH * 40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= 7'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == CFG_ACTIVE_WIDTH) shadow_width = value;
        else shadow_height = value;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
    endtask

    initial begin
        shadow_width  = 64;
        shadow_height = 64;
        shadow_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        driver_busy <= 1'b1;

        // directed: extremes, every action, saturation, zero span, ignored code
        pending_requests.push_back(make_read(0, 0));
        pending_requests.push_back(make_read(63, 63));
        pending_requests.push_back(make_fill(8, 8, 16, 16, 255, 255, 255, 255));
        pending_requests.push_back(make_read(0, 0));
        pending_requests.push_back(make_fill(0, 0, 0, 40, 255, 0, 0, 255));
        pending_requests.push_back(make_fill(3, 5, 7, 9, 255, 128, 1, 64));
        pending_requests.push_back(make_fill(20, 20, 40, 40, 200, 10, 30, 20));
        pending_requests.push_back(make_read(1, 1));
        pending_requests.push_back(make_read(2, 2));
        pending_requests.push_back(make_fill(-16'sd32768, -16'sd32768, 16'hffff,
                                             16'hffff, 0, 0, 0, 0));
        pending_requests.push_back(make_fill(1000, 1000, 24, 24, 0, 255, 255, 0));
        pending_requests.push_back(make_fill(32767, 32767, 65535, 65535, 9, 9, 9, 9));
        pending_requests.push_back(make_read(62, 62));
        pending_requests.push_back(make_read(63, 0));
        begin
            t_request r;
            r = make_read(5, 5);
            r.action = ACT_SPARE;
            pending_requests.push_back(r);
            r = make_read(0, 0);
            r.action = ACT_CLEAR;
            pending_requests.push_back(r);
        end
        pending_requests.push_back(make_read(63, 63));
        wait_drained();

        write_reg(CFG_ACTIVE_WIDTH, 1);
        write_reg(CFG_ACTIVE_HEIGHT, 1);
        pending_requests.push_back(make_fill(0, 0, 32, 32, 255, 255, 255, 128));
        pending_requests.push_back(make_read(0, 0));
        pending_requests.push_back(make_read(1, 0));
        queue_random(20);
        wait_drained();

        write_reg(CFG_ACTIVE_WIDTH, 0);
        write_reg(CFG_ACTIVE_HEIGHT, 127);
        pending_requests.push_back(make_fill(0, 0, 64, 64, 255, 255, 255, 255));
        pending_requests.push_back(make_read(0, 0));
        wait_drained();

        write_reg(CFG_ACTIVE_WIDTH, 100);
        write_reg(CFG_ACTIVE_HEIGHT, 64);
        // long receiver hold-off while reads keep coming
        long_hold_req <= 1'b1;
        for (int i = 0; i < 10; i++) pending_requests.push_back(make_read(i, 63 - i));
        queue_random(40);
        wait_drained();

        write_reg(CFG_ACTIVE_WIDTH, 37);
        write_reg(CFG_ACTIVE_HEIGHT, 0);
        queue_random(10);
        wait_drained();
        write_reg(CFG_ACTIVE_HEIGHT, 23);
        queue_random(50);
        wait_drained();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
